>>> rtl/rtts_pkg.sv
// Shared types and constants for the record to track/side/sector splitter.
`timescale 1ns / 1ps
`default_nettype none
package rtts_pkg;

  localparam int MAX_SECTORS       = 64;
  localparam int BOOT_AREA_SECTORS = 1;
  localparam int DEFAULT_GEOMETRY  = 9;

  localparam int REC_W   = 16;
  localparam int CNT_W   = 7;
  localparam int SPT_W   = 8;
  localparam int SPC_W   = 9;
  localparam int SEC_W   = 9;
  localparam int BEF_W   = 6;
  localparam int CFG_W   = 9;
  localparam int CFGIX_W = 1;

  // Register indexes on the configuration port.
  localparam logic [CFGIX_W-1:0] REG_SECTORS_PER_TRACK    = 1'd0;
  localparam logic [CFGIX_W-1:0] REG_SECTORS_PER_CYLINDER = 1'd1;

  // Request queue between front and back; depth must be a power of two.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Classified request, geometry already resolved.
  typedef struct packed {
    logic [REC_W-1:0] start_record;
    logic [CNT_W-1:0] total;
    logic             is_write;
    logic             single;
    logic [SPT_W-1:0] spt;
    logic [SPC_W-1:0] spc;
  } req_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic valid;
    req_t req;
  } qhead_t;

  typedef struct packed {
    logic [REC_W-1:0] track;
    logic             side;
    logic [SEC_W-1:0] first_sector;
    logic [CNT_W-1:0] chunk_count;
    logic [BEF_W-1:0] sectors_before;
    logic             boot_area_write;
    logic             last;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/record_to_track_side_sector.sv
// Top level of the record to track/side/sector splitter.
`timescale 1ns / 1ps
`default_nettype none
// Splits each transfer request (start record, sector count, write flag,
// single-sector flag) into per-track chunks, one result transaction per
// chunk, in order. Both sides look like a queue: push/full for requests,
// empty/pop for results. A front end classifies requests (count saturated
// at 64, zero cylinder size replaced by nine sectors per track and per
// cylinder) into a two-entry request queue; a back end walks the chunks.
// Each chunk costs a 16-step restoring division of the record by the
// cylinder size; a zero-count request skips the division and gives its
// single empty result. The result register lets new requests be queued
// while a result waits to be popped. Geometry registers are written
// through cfg_we/cfg_index/cfg_data and are taken into each request when
// it is pushed.
module record_to_track_side_sector
  import rtts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CFGIX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [REC_W-1:0]   start_record,
  input  wire logic [CNT_W-1:0]   sector_total,
  input  wire logic               is_write,
  input  wire logic               single_sector_mode,
  output logic                    empty,
  input  wire logic               pop,
  output logic [REC_W-1:0]        track,
  output logic                    side,
  output logic [SEC_W-1:0]        first_sector,
  output logic [CNT_W-1:0]        chunk_count,
  output logic [BEF_W-1:0]        sectors_before,
  output logic                    boot_area_write,
  output logic                    last
);

  qhead_t head;
  logic   take;
  res_t   result;

  // Front: config, classification, request queue.
  rtts_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .push              (push),
    .full              (full),
    .start_record      (start_record),
    .sector_total      (sector_total),
    .is_write          (is_write),
    .single_sector_mode(single_sector_mode),
    .head              (head),
    .take              (take)
  );

  // Back: chunk walk and result register.
  rtts_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .take  (take),
    .empty (empty),
    .pop   (pop),
    .result(result)
  );

  assign track           = result.track;
  assign side            = result.side;
  assign first_sector    = result.first_sector;
  assign chunk_count     = result.chunk_count;
  assign sectors_before  = result.sectors_before;
  assign boot_area_write = result.boot_area_write;
  assign last            = result.last;

endmodule
`default_nettype wire

>>> rtl/rtts_front.sv
// Front end: configuration registers, request classification and request queue.
`timescale 1ns / 1ps
`default_nettype none
module rtts_front
  import rtts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CFGIX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [REC_W-1:0]   start_record,
  input  wire logic [CNT_W-1:0]   sector_total,
  input  wire logic               is_write,
  input  wire logic               single_sector_mode,
  output qhead_t                  head,
  input  wire logic               take
);

  logic [SPT_W-1:0]  spt_reg;
  logic [SPC_W-1:0]  spc_reg;
  req_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  req_t              req_in;
  logic              do_push;
  logic              do_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      spt_reg <= '0;
      spc_reg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SECTORS_PER_TRACK:    spt_reg <= cfg_data[SPT_W-1:0];
        REG_SECTORS_PER_CYLINDER: spc_reg <= cfg_data[SPC_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero cylinder size falls back to the default geometry for both values.
  always_comb begin
    req_in.start_record = start_record;
    req_in.is_write     = is_write;
    req_in.single       = single_sector_mode;
    req_in.total        = (sector_total > CNT_W'(MAX_SECTORS)) ?
                          CNT_W'(MAX_SECTORS) : sector_total;
    if (spc_reg == '0) begin
      req_in.spt = SPT_W'(DEFAULT_GEOMETRY);
      req_in.spc = SPC_W'(DEFAULT_GEOMETRY);
    end else begin
      req_in.spt = spt_reg;
      req_in.spc = spc_reg;
    end
  end

  assign full     = (count == QCNT_W'(QDEPTH));
  assign do_push  = push && !full;
  assign do_pop   = take && (count != '0);
  assign head.valid = (count != '0);
  assign head.req   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rtts_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rtts_div
  import rtts_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [REC_W-1:0] dividend,
  input  wire logic [SPC_W-1:0] divisor,
  output logic [REC_W-1:0]      quotient,
  output logic [SPC_W-1:0]      remainder,
  output logic                  done
);

  localparam int STEP_W = $clog2(REC_W + 1);

  logic [REC_W-1:0]  quo;
  logic [SPC_W-1:0]  rem;
  logic [SPC_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic [SPC_W:0]    trial;
  logic              fits;
  logic [SPC_W:0]    diff;

  assign trial = {rem, quo[REC_W-1]};
  assign fits  = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (steps != '0) begin
      quo <= {quo[REC_W-2:0], fits};
      rem <= fits ? diff[SPC_W-1:0] : trial[SPC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= (steps == STEP_W'(1)) && !start;
      if (start)            steps <= STEP_W'(REC_W);
      else if (steps != '0) steps <= steps - 1'b1;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule
`default_nettype wire

>>> rtl/rtts_back.sv
// Back end: chunk sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module rtts_back
  import rtts_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire qhead_t head,
  output logic        take,
  output logic        empty,
  input  wire logic   pop,
  output res_t        result
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_ZERO  = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [REC_W-1:0] record;
  logic [CNT_W-1:0] remaining;
  logic [CNT_W-1:0] done_cnt;
  logic             wr;
  logic             single;
  logic [SPT_W-1:0] spt;
  logic [SPC_W-1:0] spc;

  logic             div_start;
  logic [REC_W-1:0] quo;
  logic [SPC_W-1:0] rem;
  logic             div_done;

  logic             out_valid;
  logic             slot_free;
  logic             load;
  res_t             chunk;
  logic             side;
  logic [SEC_W-1:0] sec;
  logic [SEC_W-1:0] room;
  logic [CNT_W-1:0] num;

  rtts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (record),
    .divisor  (spc),
    .quotient (quo),
    .remainder(rem),
    .done     (div_done)
  );

  assign div_start = (state == ST_START);
  assign take      = (state == ST_IDLE) && head.valid;
  assign slot_free = !out_valid || pop;
  assign load      = slot_free && ((state == ST_EMIT) || (state == ST_ZERO));

  // Split the remainder into side and sector; clamp the chunk at track end.
  always_comb begin
    side = (rem >= {1'b0, spt});
    sec  = side ? (rem - {1'b0, spt}) : rem;
    room = {1'b0, spt} - sec;
    if (single || (sec >= {1'b0, spt})) begin
      num = CNT_W'(1);
    end else if (room < {2'b0, remaining}) begin
      num = room[CNT_W-1:0];
    end else begin
      num = remaining;
    end
    chunk = '0;
    if (state == ST_EMIT) begin
      chunk.track           = quo;
      chunk.side            = side;
      chunk.first_sector    = sec + 1'b1;
      chunk.chunk_count     = num;
      chunk.sectors_before  = done_cnt[BEF_W-1:0];
      chunk.boot_area_write = wr && (quo == '0) && !side &&
                              (sec < SEC_W'(BOOT_AREA_SECTORS));
      chunk.last            = (num == remaining);
    end else begin
      chunk.last = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          state_next = (head.req.total == '0) ? ST_ZERO : ST_START;
        end
      end
      ST_START: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) state_next = (num == remaining) ? ST_IDLE : ST_START;
      end
      ST_ZERO: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load)     out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      record    <= head.req.start_record;
      remaining <= head.req.total;
      done_cnt  <= '0;
      wr        <= head.req.is_write;
      single    <= head.req.single;
      spt       <= head.req.spt;
      spc       <= head.req.spc;
    end else if (load && (state == ST_EMIT)) begin
      record    <= record + REC_W'(num);
      remaining <= remaining - num;
      done_cnt  <= done_cnt + num;
    end
  end

  always_ff @(posedge clk) begin
    if (load) result <= chunk;
  end

  assign empty = !out_valid;

  a_num_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (num != '0 && num <= remaining))
    else $error("chunk size outside remaining count");

  a_last_ends_request: assert property (@(posedge clk) disable iff (rst)
    (load && chunk.last) |=> (state == ST_IDLE))
    else $error("sequencer kept running after final chunk");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside wait state");

  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    take |=> (state == ST_START || state == ST_ZERO))
    else $error("request taken without starting work");

endmodule
`default_nettype wire
